/* rtl/multi_waveform_oscillator_core_assert.svh */
// assertion macros for the multi-waveform oscillator core
// expects a clock named aclk and an active-low reset named aresetn in the including module
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define MWO_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("multi_waveform_oscillator_core: check failed");

// next-cycle implication
`define MWO_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("multi_waveform_oscillator_core: check failed");

`endif

/* rtl/mwo_pkg.sv */
// shared constants, types and the quarter-wave sine table function
// for the multi-waveform oscillator core; no dependencies
package mwo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 16;

    localparam int FREQ_W      = 21;
    localparam int RATE_W      = 18;
    localparam int SHAPE_W     = 3;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int DIV_W       = 25;
    localparam int COUNT_W     = $clog2(DIV_W + 1);
    localparam int CFG_INDEX_W = 8;

    localparam int S_TDATA_W = ((FREQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    localparam int SINE_ENTRIES = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int IDX_W        = SINE_TABLE_BITS + 2;
    localparam int IDX_SHR      = (PHASE_BITS >= IDX_W) ? PHASE_BITS - IDX_W : 0;
    localparam int IDX_SHL      = (PHASE_BITS >= IDX_W) ? 0 : IDX_W - PHASE_BITS;
    localparam int IDX_WIDE_W   = PHASE_BITS + IDX_SHL;

    localparam int WAVE_W = PHASE_BITS + 2;
    localparam logic [WAVE_W-1:0] PHASE_ONE = WAVE_W'(1) << PHASE_BITS;

    localparam logic [MAG_W-1:0] FULL_SCALE      = MAG_W'(32767);
    localparam logic [DIV_W-1:0] RATE_X100_RESET = DIV_W'(44100 * 100);
    localparam longint unsigned  HALF_PI_Q30     = 64'd1686629713;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW_REV  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SHAPE  = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_MOD,
        ST_PHASE,
        ST_LOOKUP,
        ST_EMIT
    } mwo_state_t;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] steps;
        logic [DIV_W-1:0]   rem_init;
        logic [DIV_W-1:0]   dividend;
        logic [DIV_W-1:0]   divisor;
    } dv_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } dv_rsp_t;

    // taylor series of sin through x^13 in unsigned q30, every step truncated
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(j) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        term = ((term * x2) >> 30) / 6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 156;
        pos  = pos + term;
        sum  = (pos > neg) ? pos - neg : 64'd0;
        v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return MAG_W'(v);
    endfunction

endpackage

/* rtl/mwo_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on mwo_pkg for widths and the request/response structs
module mwo_divider
    import mwo_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  dv_req_t req,
    output dv_rsp_t rsp
);

    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   dsr_reg, dsr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};

        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (req.start) begin
            rem_next = req.rem_init;
            dvd_next = req.dividend;
            quo_next = '0;
            dsr_next = req.divisor;
            cnt_next = req.steps;
        end else if (cnt_reg != '0) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next  = {dvd_reg[DIV_W-2:0], 1'b0};
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - COUNT_W'(1);
            done_next = (cnt_reg == COUNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/mwo_sine_rom.sv */
// quarter-wave sine rom with registered read, entries 0 to 2^SINE_TABLE_BITS
// depends on mwo_pkg for the table function and widths
module mwo_sine_rom
    import mwo_pkg::*;
(
    input  logic                   aclk,
    input  logic [SINE_ADDR_W-1:0] addr,
    output logic [MAG_W-1:0]       data
);

    logic [MAG_W-1:0] rom_words [SINE_ENTRIES];
    logic [MAG_W-1:0] data_reg;

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
        localparam logic [MAG_W-1:0] WORD = quarter_sine(g);
        assign rom_words[g] = WORD;
    end

    always_ff @(posedge aclk) begin
        data_reg <= rom_words[addr];
    end

    assign data = data_reg;

endmodule

/* rtl/mwo_shaper.sv */
// turns a phase into one q1.15 sample of the selected shape, and
// gives the sine rom address; depends on mwo_pkg
module mwo_shaper
    import mwo_pkg::*;
(
    input  logic [SHAPE_W-1:0]     shape,
    input  logic [PHASE_BITS-1:0]  phase,
    input  logic                   square_pos,
    input  logic [MAG_W-1:0]       sine_mag,
    output logic [SINE_ADDR_W-1:0] sine_addr,
    output logic [SAMPLE_W-1:0]    sample
);

    logic [IDX_WIDE_W-1:0]      idx_wide;
    logic [IDX_W-1:0]           idx;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] k;

    logic [WAVE_W-1:0] twice;
    logic              saw_up;
    logic [WAVE_W-1:0] saw_mag;
    logic [WAVE_W-1:0] tri_dd;
    logic              tri_up;
    logic [WAVE_W-1:0] tri_mag;

    logic                         lin_neg;
    logic [WAVE_W-1:0]            lin_mag;
    logic [PHASE_BITS+MAG_W-1:0]  scaled;
    logic [MAG_W-1:0]             lin_r;
    logic [SAMPLE_W-1:0]          lin_val;
    logic [SAMPLE_W-1:0]          sine_val;

    always_comb begin
        idx_wide  = IDX_WIDE_W'(phase) << IDX_SHL;
        idx       = IDX_W'(idx_wide >> IDX_SHR);
        quad      = idx[IDX_W-1:IDX_W-2];
        k         = idx[SINE_TABLE_BITS-1:0];
        // odd quadrants mirror the table
        sine_addr = quad[0] ? (SINE_ADDR_W'(1) << SINE_TABLE_BITS) - {1'b0, k} : {1'b0, k};
        sine_val  = quad[1] ? -{1'b0, sine_mag} : {1'b0, sine_mag};

        twice   = {1'b0, phase, 1'b0};
        saw_up  = twice >= PHASE_ONE;
        saw_mag = saw_up ? twice - PHASE_ONE : PHASE_ONE - twice;
        tri_dd  = {saw_mag[WAVE_W-2:0], 1'b0};
        tri_up  = tri_dd >= PHASE_ONE;
        tri_mag = tri_up ? tri_dd - PHASE_ONE : PHASE_ONE - tri_dd;

        lin_neg = 1'b0;
        lin_mag = '0;
        unique case (shape)
            SHAPE_TRIANGLE: begin
                lin_neg = !tri_up;
                lin_mag = tri_mag;
            end
            SHAPE_SAW: begin
                lin_neg = !saw_up;
                lin_mag = saw_mag;
            end
            SHAPE_SAW_REV: begin
                lin_neg = saw_up;
                lin_mag = saw_mag;
            end
            default: begin
                lin_neg = 1'b0;
                lin_mag = '0;
            end
        endcase

        // mag * 32767 rounded half up, then back to q1.15
        scaled = ((PHASE_BITS + MAG_W)'(lin_mag) << MAG_W) - (PHASE_BITS + MAG_W)'(lin_mag)
               + ((PHASE_BITS + MAG_W)'(1) << (PHASE_BITS - 1));
        lin_r   = scaled[PHASE_BITS+MAG_W-1:PHASE_BITS];
        lin_val = lin_neg ? -{1'b0, lin_r} : {1'b0, lin_r};

        unique case (shape)
            SHAPE_SINE:     sample = sine_val;
            SHAPE_SQUARE:   sample = square_pos ? {1'b0, FULL_SCALE} : -{1'b0, FULL_SCALE};
            SHAPE_TRIANGLE: sample = lin_val;
            SHAPE_SAW:      sample = lin_val;
            SHAPE_SAW_REV:  sample = lin_val;
            default:        sample = '0;
        endcase
    end

endmodule

/* rtl/multi_waveform_oscillator_core.sv */
// Counter-based oscillator with five shapes (sine, square, triangle, sawtooth, reverse
// sawtooth). Each input item carries a frequency in hundredths of a hertz and yields one
// Q1.15 sample; a zero frequency yields 0 and leaves the sample counter alone. One shared
// restoring divider, one quotient bit per cycle, runs three passes per nonzero-frequency
// item: period from the sample rate, counter modulo period, and the 16-bit phase fraction.
// After the passes come a sine rom read and the output load, which waits while the output
// register is full; a zero frequency goes straight to the output load. The core then
// returns to idle. Results sit in an output register, so the next item is accepted as
// soon as the last one is loaded there. Write the rate and shape registers only while
// idle.
// depends on mwo_pkg, mwo_divider, mwo_sine_rom, mwo_shaper and the assertion macro header
`include "multi_waveform_oscillator_core_assert.svh"

module multi_waveform_oscillator_core
    import mwo_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel: index 0 output rate, index 1 wave_shape
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]      cfg_data,
    // input item
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [20:0] freq_centihz
    // result item
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [15:0] sample_value
);

    mwo_state_t state_reg, state_next;

    logic [DIV_W-1:0]      rate_x100_reg;
    logic [SHAPE_W-1:0]    wave_shape_reg;
    logic [DIV_W-1:0]      counter_reg, counter_next;
    logic [DIV_W-1:0]      period_reg, period_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  square_pos_reg, square_pos_next;
    logic                  zero_reg, zero_next;
    logic [SAMPLE_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [FREQ_W-1:0]      freq;
    logic [DIV_W-1:0]       rate_in;
    logic [DIV_W:0]         q_inc;
    dv_req_t                dv_req;
    dv_rsp_t                dv_rsp;
    logic [SINE_ADDR_W-1:0] sine_addr;
    logic [MAG_W-1:0]       sine_mag;
    logic [SAMPLE_W-1:0]    sample;

    assign freq      = s_tdata[FREQ_W-1:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // sample_rate widened here; the config write multiplies it by 100 as shifts and adds
    assign rate_in = DIV_W'(cfg_data);

    mwo_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dv_req),
        .rsp     (dv_rsp)
    );

    mwo_sine_rom u_sine_rom (
        .aclk (aclk),
        .addr (sine_addr),
        .data (sine_mag)
    );

    mwo_shaper u_shaper (
        .shape      (wave_shape_reg),
        .phase      (phase_reg),
        .square_pos (square_pos_reg),
        .sine_mag   (sine_mag),
        .sine_addr  (sine_addr),
        .sample     (sample)
    );

    always_comb begin
        state_next      = state_reg;
        counter_next    = counter_reg;
        period_next     = period_reg;
        phase_next      = phase_reg;
        square_pos_next = square_pos_reg;
        zero_next       = zero_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        q_inc           = {1'b0, dv_rsp.remainder} + (DIV_W + 1)'(1);
        dv_req          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    zero_next = (freq == '0);
                    if (freq == '0) begin
                        state_next = ST_EMIT;
                    end else begin
                        dv_req.start    = 1'b1;
                        dv_req.steps    = COUNT_W'(DIV_W);
                        dv_req.dividend = rate_x100_reg;
                        dv_req.divisor  = DIV_W'(freq);
                        state_next      = ST_PERIOD;
                    end
                end
            end
            ST_PERIOD: begin
                if (dv_rsp.done) begin
                    period_next     = (dv_rsp.quotient == '0) ? DIV_W'(1) : dv_rsp.quotient;
                    dv_req.start    = 1'b1;
                    dv_req.steps    = COUNT_W'(DIV_W);
                    dv_req.dividend = counter_reg;
                    dv_req.divisor  = period_next;
                    state_next      = ST_MOD;
                end
            end
            ST_MOD: begin
                if (dv_rsp.done) begin
                    counter_next    = (q_inc == {1'b0, period_reg}) ? '0 : q_inc[DIV_W-1:0];
                    square_pos_next = dv_rsp.remainder < (period_reg >> 1);
                    dv_req.start    = 1'b1;
                    dv_req.steps    = COUNT_W'(PHASE_BITS);
                    dv_req.rem_init = dv_rsp.remainder;
                    dv_req.divisor  = period_reg;
                    state_next      = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (dv_rsp.done) begin
                    phase_next = dv_rsp.quotient[PHASE_BITS-1:0];
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = zero_reg ? '0 : sample;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        period_reg     <= period_next;
        phase_reg      <= phase_next;
        square_pos_reg <= square_pos_next;
        zero_reg       <= zero_next;
        m_tdata_reg    <= m_tdata_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            counter_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            rate_x100_reg  <= RATE_X100_RESET;
            wave_shape_reg <= SHAPE_SINE;
        end else begin
            state_reg    <= state_next;
            counter_reg  <= counter_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SAMPLE_RATE) begin
                    rate_x100_reg <= (rate_in << 6) + (rate_in << 5) + (rate_in << 2);
                end else if (cfg_index == REG_WAVE_SHAPE) begin
                    wave_shape_reg <= cfg_data[SHAPE_W-1:0];
                end
            end
        end
    end

    `MWO_ASSERT_IMPL(a_counter_below_period, state_reg == ST_PHASE, counter_reg < period_reg)
    `MWO_ASSERT_IMPL(a_period_nonzero, state_reg == ST_MOD, period_reg != '0)
    `MWO_ASSERT_IMPL(a_done_while_dividing, dv_rsp.done,
                     state_reg == ST_PERIOD || state_reg == ST_MOD || state_reg == ST_PHASE)
    `MWO_ASSERT_NEXT(a_silent_item_skips, s_tvalid && s_tready && freq == '0,
                     state_reg == ST_EMIT && $stable(counter_reg))
    `MWO_ASSERT_NEXT(a_emit_waits, state_reg == ST_EMIT && m_tvalid && !m_tready,
                     state_reg == ST_EMIT)

endmodule

/* test/oscillator_checker.sv */
// watches the config, input and result channels of the oscillator core, predicts every
// sample from its own copy of the registers and counter, and compares; depends on mwo_pkg
`timescale 1ns / 100ps

module oscillator_checker
    import mwo_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int unsigned            outstanding,
    output int unsigned            mismatches
);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam int QUARTER = 1 << SINE_TABLE_BITS;

    logic [RATE_W-1:0]          model_rate;
    logic [SHAPE_W-1:0]         model_shape;
    logic [DIV_W-1:0]           osc_count;
    int unsigned                sine_quarter [0:QUARTER];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int unsigned                error_count;

    // sin(x) by taylor series through x^13, unsigned q30, each step truncated
    function automatic int unsigned taylor_sine(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned sum;
        longint unsigned v;
        bit              minus;
        x     = (64'(j) * HALF_PI_Q30) >> SINE_TABLE_BITS;
        x2    = (x * x) >> 30;
        term  = x;
        pos   = x;
        neg   = 0;
        minus = 1'b1;
        for (int n = 1; n <= 11; n += 2) begin
            term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
            if (minus) begin
                neg += term;
            end else begin
                pos += term;
            end
            minus = !minus;
        end
        sum = (pos > neg) ? pos - neg : 64'd0;
        v   = (sum * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
        if (v > 64'(FULL_SCALE)) begin
            v = 64'(FULL_SCALE);
        end
        return int'(v);
    endfunction

    // |v| / 2^PHASE_BITS to q1.15, round half away from zero
    function automatic int scale_q15(input bit negative, input longint unsigned mag);
        longint unsigned r;
        r = (mag * 64'(FULL_SCALE) + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS;
        if (r > 64'(FULL_SCALE)) begin
            r = 64'(FULL_SCALE);
        end
        return negative ? -int'(r) : int'(r);
    endfunction

    // sample for one item; steps the counter unless the frequency is zero
    function automatic logic signed [SAMPLE_W-1:0] advance_oscillator(
        input logic [FREQ_W-1:0] freq
    );
        longint unsigned period;
        longint unsigned rem;
        longint unsigned phase;
        longint unsigned twice;
        longint unsigned tri_span;
        longint unsigned full;
        longint unsigned idx;
        longint unsigned quad;
        longint unsigned k;
        int              value;
        full  = 64'd1 << PHASE_BITS;
        value = 0;
        if (freq == '0) begin
            return '0;
        end
        period = (64'(model_rate) * 100) / 64'(freq);
        if (period == 0) begin
            period = 1;
        end
        rem   = 64'(osc_count) % period;
        phase = (rem << PHASE_BITS) / period;
        twice = 2 * phase;
        case (model_shape)
            SHAPE_SINE: begin
                idx  = phase >> (PHASE_BITS - IDX_W);
                quad = (idx >> SINE_TABLE_BITS) & 3;
                k    = idx & (QUARTER - 1);
                value = int'(sine_quarter[(quad % 2 == 1) ? QUARTER - k : k]);
                if (quad >= 2) begin
                    value = -value;
                end
            end
            SHAPE_SQUARE: begin
                value = (rem < period / 2) ? int'(FULL_SCALE) : -int'(FULL_SCALE);
            end
            SHAPE_TRIANGLE: begin
                tri_span = (twice >= full) ? twice - full : full - twice;
                tri_span = 2 * tri_span;
                value = (tri_span >= full) ? scale_q15(1'b0, tri_span - full)
                                           : scale_q15(1'b1, full - tri_span);
            end
            SHAPE_SAW: begin
                value = (twice >= full) ? scale_q15(1'b0, twice - full)
                                        : scale_q15(1'b1, full - twice);
            end
            SHAPE_SAW_REV: begin
                value = (twice >= full) ? scale_q15(1'b1, twice - full)
                                        : scale_q15(1'b0, full - twice);
            end
            default: begin
                value = 0;
            end
        endcase
        osc_count = DIV_W'((64'(osc_count) + 1) % period);
        return SAMPLE_W'(value);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    initial begin
        for (int j = 0; j <= QUARTER; j++) begin
            sine_quarter[j] = taylor_sine(j);
        end
    end

    always @(posedge aclk) begin : monitor
        logic signed [SAMPLE_W-1:0] got;
        logic signed [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            model_rate  = RATE_RESET;
            model_shape = SHAPE_SINE;
            osc_count   = '0;
            expected_samples.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[SAMPLE_W-1:0];
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample with none expected", got, 0);
                end else begin
                    want = expected_samples.pop_front();
                    if (got !== want) begin
                        report_mismatch("sample_value", got, want);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SAMPLE_RATE: model_rate = cfg_data;
                    REG_WAVE_SHAPE:  model_shape = cfg_data[SHAPE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_samples.push_back(advance_oscillator(s_tdata[FREQ_W-1:0]));
            end
        end
        outstanding <= expected_samples.size();
        mismatches  <= error_count;
    end

endmodule

/* test/tb_top.sv */
// top of the oscillator core testbench: clock, reset, config writes, frequency stimulus
// and result back-pressure; depends on mwo_pkg, the core and oscillator_checker
`timescale 1ns / 100ps

module tb_top;
    import mwo_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE      = 8'hFF;
    localparam logic [SHAPE_W-1:0]     SHAPE_SPARE_LO = 3'd5;
    localparam logic [SHAPE_W-1:0]     SHAPE_SPARE_HI = 3'd7;
    localparam logic [RATE_W-1:0]      RATE_MIN       = RATE_W'(1000);
    localparam logic [RATE_W-1:0]      RATE_TOP       = RATE_W'(192000);
    localparam logic [RATE_W-1:0]      RATE_CD        = RATE_W'(44100);
    localparam logic [RATE_W-1:0]      RATE_DAT       = RATE_W'(48000);
    localparam logic [RATE_W-1:0]      RATE_MAX       = '1;
    localparam int PHASES     = 12;
    localparam int PER_PHASE  = 112;
    localparam int IDLE_GAP   = 8;
    localparam int LONG_HOLD  = 600;
    localparam int TAIL       = 100;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [RATE_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int unsigned       outstanding;
    int unsigned       mismatches;
    int                burst_left    = 0;
    int                hold_requests = 0;
    int                holds_done    = 0;
    logic [RATE_W-1:0] cur_rate      = RATE_CD;

    multi_waveform_oscillator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    oscillator_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #1 aclk = ~aclk;

    // stops offering items and waits for every sample to come back
    task automatic settle_block();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [RATE_W-1:0] value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (index == REG_SAMPLE_RATE) begin
            cur_rate = value;
        end
    endtask

    // valid stays high between items of a burst
    task automatic send_freq(input logic [FREQ_W-1:0] freq);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(freq);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_run(input logic [FREQ_W-1:0] freq, input int count);
        repeat (count) send_freq(freq);
    endtask

    function automatic logic [FREQ_W-1:0] freq_for_period(input int unsigned p);
        longint unsigned f;
        f = (64'(cur_rate) * 100) / p;
        if (f == 0) begin
            f = $urandom_range(1, 5000);
        end
        if (f >= (64'd1 << FREQ_W)) begin
            f = (64'd1 << FREQ_W) - 1;
        end
        return FREQ_W'(f);
    endfunction

    // receiver: stall patterns in segments, plus long hold-offs on request
    initial begin : receiver
        int seg;
        int mode;
        int cyc;
        cyc = 0;
        @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end
            seg  = $urandom_range(10, 150);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= (cyc % 5 != 0);
                endcase
                cyc++;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int                 sent;
        int                 kind;
        int                 len;
        int unsigned        p;
        logic [FREQ_W-1:0]  f;
        logic [RATE_W-1:0]  r;
        logic [SHAPE_W-1:0] sh;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, sine
        send_freq('0);
        send_run(FREQ_W'(1), 2);
        send_run('1, 2);
        send_freq(FREQ_W'(2000000));
        send_freq(FREQ_W'(44100));
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_SQUARE));
        send_run(FREQ_W'(1470000), 3);
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_TRIANGLE));
        send_run(FREQ_W'(1102500), 4);
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_SAW));
        send_run(FREQ_W'(1102500), 2);
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_SAW_REV));
        send_run(FREQ_W'(1102500), 2);
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_SPARE_LO));
        send_freq(FREQ_W'(100));
        // zero rate: period is forced to one
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_SPARE_HI));
        write_reg(REG_SAMPLE_RATE, '0);
        send_freq(FREQ_W'(1));
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_TRIANGLE));
        send_freq(FREQ_W'(5));
        write_reg(REG_SAMPLE_RATE, RATE_MAX);
        write_reg(REG_WAVE_SHAPE, RATE_W'(SHAPE_SINE));
        send_freq(FREQ_W'(1));
        send_freq('0);
        write_reg(REG_SAMPLE_RATE, RATE_MIN);
        send_freq(FREQ_W'(2000000));
        // write to an unused index leaves the registers alone
        write_reg(REG_SPARE, '1);
        send_freq('1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: r = RATE_MIN;
                1: r = RATE_TOP;
                2: r = RATE_CD;
                3: r = RATE_DAT;
                4: r = '0;
                5: r = RATE_MAX;
                default: r = RATE_W'($urandom_range(RATE_MIN, RATE_TOP));
            endcase
            sh = (ph < 8) ? SHAPE_W'(ph) : SHAPE_W'($urandom_range(0, 4));
            write_reg(REG_WAVE_SHAPE, RATE_W'(sh));
            write_reg(REG_SAMPLE_RATE, r);
            if (ph == 6) begin
                write_reg(REG_SPARE, '1);
            end
            if (ph == 3 || ph == 8) begin
                hold_requests++;
            end
            sent = 0;
            while (sent < PER_PHASE) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    // steady tone, walks the counter through the waveform
                    p = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 5000)
                                                    : $urandom_range(1, 64);
                    len = $urandom_range(3, 48);
                    if (len > PER_PHASE - sent) begin
                        len = PER_PHASE - sent;
                    end
                    send_run(freq_for_period(p), len);
                    sent += len;
                end else if (kind < 9) begin
                    f = FREQ_W'($urandom);
                    send_freq(f);
                    sent++;
                end else begin
                    send_freq('0);
                    sent++;
                end
            end
        end

        settle_block();
        repeat (TAIL) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mwo_pkg.sv
rtl/mwo_divider.sv
rtl/mwo_sine_rom.sv
rtl/mwo_shaper.sv
rtl/multi_waveform_oscillator_core.sv
test/oscillator_checker.sv
test/tb_top.sv
